// ===== hdl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII package
// Widths and character codes shared by the converter and its checker.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 64;
  localparam int INPUT_WIDTH         = 64;
  localparam int CHAR_WIDTH          = 8;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'h2D;

endpackage

// ===== hdl/signed_binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII converter
// Converts one two's complement integer per transaction into its decimal
// text, one ASCII character per output transaction, with tlast on the final one.
// ----------------------------------------------------------------------------
// Operation: a value is accepted, its magnitude is converted by shift-and-add-3 in
// the shared BCD correction unit, a minus sign is sent first for a negative
// value, then leading zeros are skipped and the remaining digits are emitted.
// Acceptance: a new value is taken only once the last character of the previous
// one has been loaded into the output register; a stalled output holds emission.
// Reset: rst is synchronous and active high; it idles the sequencer and
// empties the output register.
module signed_binary_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = sbda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0 up: value.
  input  logic [sbda_pkg::INPUT_WIDTH-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0 up: character.
  output logic [sbda_pkg::CHAR_WIDTH-1:0]  m_tdata,
  output logic                             m_tlast
);
  import sbda_pkg::*;

  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_WIDTH  = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state, state_next;
  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic [BCD_WIDTH-1:0]   bcd, bcd_next;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  logic [DIG_CNT_W-1:0]   dig_cnt, dig_cnt_next;
  logic                   neg, neg_next;
  logic                   started, started_next;
  logic                   out_valid, out_valid_next;
  logic [CHAR_WIDTH-1:0]  out_char, out_char_next;
  logic                   out_last, out_last_next;

  logic [VALUE_WIDTH-1:0] value_in;
  logic [3:0]             top_digit;
  logic                   out_free;

  assign value_in  = s_tdata[VALUE_WIDTH-1:0];
  assign top_digit = bcd[BCD_WIDTH-1 -: 4];
  assign out_free  = !out_valid || m_tready;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3 : bcd[d*4 +: 4];
    end
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    bcd_next       = bcd;
    bit_cnt_next   = bit_cnt;
    dig_cnt_next   = dig_cnt;
    neg_next       = neg;
    started_next   = started;
    out_valid_next = out_valid && !m_tready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          neg_next     = value_in[VALUE_WIDTH-1];
          mag_next     = value_in[VALUE_WIDTH-1] ? (~value_in + 1'b1) : value_in;
          bcd_next     = '0;
          bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_next     = {bcd_adj[BCD_WIDTH-2:0], mag[VALUE_WIDTH-1]};
        mag_next     = {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
          started_next = 1'b0;
          state_next   = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = ASCII_MINUS;
          out_last_next  = 1'b0;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started && top_digit == 4'd0 && dig_cnt != DIG_CNT_W'(1)) begin
          bcd_next     = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = ASCII_ZERO + {4'd0, top_digit};
          out_last_next  = (dig_cnt == DIG_CNT_W'(1));
          bcd_next       = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next   = dig_cnt - 1'b1;
          started_next   = 1'b1;
          if (dig_cnt == DIG_CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
      dig_cnt   <= '0;
      started   <= 1'b0;
      neg       <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      bit_cnt   <= bit_cnt_next;
      dig_cnt   <= dig_cnt_next;
      started   <= started_next;
      neg       <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    bcd      <= bcd_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

endmodule

// ===== hdl/sbda_checker.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII checker
// Port-level assertions for the converter, bound to its top level.
// ----------------------------------------------------------------------------
module sbda_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sbda_pkg::CHAR_WIDTH-1:0] m_tdata,
  input logic                            m_tlast
);
  import sbda_pkg::*;

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input ready right after an accepted transaction.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output transaction changed.");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == ASCII_MINUS) || (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE))
    else $error("Output character is not a digit or minus sign.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == ASCII_MINUS |-> !m_tlast)
    else $error("Minus sign flagged as the last character.");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
